>>> src/haversine_distance_assert.svh
// assertion macros used by the haversine distance top level
`ifndef HAVERSINE_DISTANCE_ASSERT_SVH
`define HAVERSINE_DISTANCE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HVD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("haversine_distance: same-cycle check failed");

// next-cycle implication, checked out of reset
`define HVD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("haversine_distance: next-cycle check failed");

`endif

>>> src/hvd_pkg.sv
// constants, types and helper functions of the haversine distance pipeline
package hvd_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 24;

  // width of a reduced angle magnitude
  localparam int ANG_W = 26;

  localparam logic [31:0] PI_Q     = 32'd3373259426;
  localparam logic [31:0] GAIN_Q   = 32'd652032874;
  localparam logic [31:0] ONE_Q    = 32'd1073741824;
  localparam logic [12:0] DIAMETER = 13'd7912;
  localparam logic [21:0] MILES_CAP = 22'd3181568;

  // floor(2^37 / 45), for dividing by 180 after a shift by two
  localparam logic [63:0] RECIP45_W = (64'd1 << 37) / 64'd45;
  localparam logic [31:0] RECIP45   = RECIP45_W[31:0];

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } sq_t;

  // atan(2^-i) in Q2.30
  function automatic logic [31:0] atan_q(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd843314857;
      1: r = 32'd497837829;
      2: r = 32'd263043837;
      3: r = 32'd133525159;
      4: r = 32'd67021687;
      5: r = 32'd33543516;
      6: r = 32'd16775851;
      7: r = 32'd8388437;
      8: r = 32'd4194283;
      9: r = 32'd2097149;
      default: begin
        if (i <= 30) r = 32'd1 << (30 - i);
        else r = 32'd0;
      end
    endcase
    return r;
  endfunction

  // conditional subtract steps that bring a 26-bit magnitude below a full turn
  function automatic int red_steps(input int fb);
    logic [63:0] full;
    int n;
    full = 64'd360 << fb;
    n = 0;
    for (int k = 0; k < 40; k++) begin
      if ((full << k) < (64'd1 << ANG_W)) n = k + 1;
    end
    return (n < 1) ? 1 : n;
  endfunction

  // one digit-pair step of the restoring integer square root
  function automatic sq_t sq_step(input sq_t cur, input int idx);
    logic [63:0] bitv;
    logic [63:0] trial;
    sq_t nxt;
    bitv = 64'd1 << (62 - 2 * idx);
    trial = cur.res + bitv;
    if (cur.v >= trial) begin
      nxt.v = cur.v - trial;
      nxt.res = (cur.res >> 1) + bitv;
    end else begin
      nxt.v = cur.v;
      nxt.res = cur.res >> 1;
    end
    return nxt;
  endfunction

endpackage

>>> src/haversine_distance.sv
// haversine great-circle distance, fully pipelined top level
// Usage:
//  in channel: one beat per point pair, tdata holds src_lat, src_lon, dst_lat,
//  dst_lon in signed degrees with FRAC_BITS fraction bits.
//  out channel: one beat per input beat, in order, tdata holds miles as
//  unsigned fixed point with 8 fraction bits, saturated at half the globe.
// Throughput: one pair per cycle while in_tready is high; every stage holds one item and its valid bit.
// Depth: the angle-reduction subtract stages (2 at FRAC_BITS 16), the two
//  cordics and the 32-stage square roots set the pipeline depth.
// Stall: the whole pipeline moves together; an output register plus a one-deep
//  skid buffer keep in_tready high while a finished beat waits, and in_tready
//  drops only once the skid buffer holds a beat too.
// Reset: clears all valid bits and the valid flags of both output buffers; no other state.
`include "haversine_distance_assert.svh"

module haversine_distance #(
  parameter int FRAC_BITS    = hvd_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = hvd_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // src_lat[23:0], src_lon[48:24], dst_lat[72:49], dst_lon[97:73]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata   // miles[21:0]
);

  localparam int RS = hvd_pkg::red_steps(FRAC_BITS);
  localparam int TL = RS + CORDIC_STEPS + 8;
  localparam int NV = 1 + TL + 4 + 32 + CORDIC_STEPS + 2;

  logic               en;
  logic               v_r [NV];
  logic signed [23:0] lat1_r, lat2_r;
  logic signed [24:0] lon1_r, lon2_r;
  logic signed [25:0] dlat, dlon, lat1_x, lat2_x;
  logic [30:0]        s1, s2;
  logic signed [31:0] c1, c2;
  logic signed [63:0] prodcc_r, tprod_r, u_r;
  logic [61:0]        s1sq_r, s1sq_b_r, s1sq_c_r;
  logic [30:0]        s2a_r, s2b_r;
  logic [60:0]        a_r, b_r;
  hvd_pkg::sq_t       rt_r [32];
  hvd_pkg::sq_t       qt_r [32];
  logic signed [34:0] ax_r [CORDIC_STEPS];
  logic signed [34:0] ay_r [CORDIC_STEPS];
  logic signed [33:0] az_r [CORDIC_STEPS];
  logic [45:0]        mul_r;
  logic [21:0]        sat_r;
  logic               out_tvalid_r;
  logic [21:0]        out_r;
  logic               skid_full_r;
  logic [21:0]        skid_r;

  // pipeline advances whenever the skid buffer is free
  assign en        = !skid_full_r;
  assign in_tready = en;

  // valid bits ride along with the data
  for (genvar k = 0; k < NV; k++) begin : g_v
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k - 1];
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r <= $signed(in_tdata[23:0]);
      lon1_r <= $signed(in_tdata[48:24]);
      lat2_r <= $signed(in_tdata[72:49]);
      lon2_r <= $signed(in_tdata[97:73]);
    end
  end

  // half-angle differences carry one extra fraction bit
  assign dlat   = 26'(lat2_r) - 26'(lat1_r);
  assign dlon   = 26'(lon2_r) - 26'(lon1_r);
  assign lat1_x = 26'(lat1_r);
  assign lat2_x = 26'(lat2_r);

  hvd_trig #(.FB(FRAC_BITS + 1), .RED_STEPS(RS), .CORDIC_STEPS(CORDIC_STEPS)) u_trig_dlat (
    .clk(clk), .en(en), .ang_i(dlat), .s_o(s1), .c_o()
  );
  hvd_trig #(.FB(FRAC_BITS + 1), .RED_STEPS(RS), .CORDIC_STEPS(CORDIC_STEPS)) u_trig_dlon (
    .clk(clk), .en(en), .ang_i(dlon), .s_o(s2), .c_o()
  );
  hvd_trig #(.FB(FRAC_BITS), .RED_STEPS(RS), .CORDIC_STEPS(CORDIC_STEPS)) u_trig_lat1 (
    .clk(clk), .en(en), .ang_i(lat1_x), .s_o(), .c_o(c1)
  );
  hvd_trig #(.FB(FRAC_BITS), .RED_STEPS(RS), .CORDIC_STEPS(CORDIC_STEPS)) u_trig_lat2 (
    .clk(clk), .en(en), .ang_i(lat2_x), .s_o(), .c_o(c2)
  );

  // a = s1^2 + floor(floor(c1 c2) s2) s2, one product per stage
  always_ff @(posedge clk) begin
    logic signed [31:0] cc, t;
    logic signed [64:0] asum;
    if (en) begin
      prodcc_r <= 64'(c1) * 64'(c2);
      s1sq_r   <= {31'd0, s1} * {31'd0, s1};
      s2a_r    <= s2;
      cc = 32'(prodcc_r >>> 30);
      tprod_r  <= 64'(cc) * 64'($signed({1'b0, s2a_r}));
      s1sq_b_r <= s1sq_r;
      s2b_r    <= s2a_r;
      t = 32'(tprod_r >>> 30);
      u_r      <= 64'(t) * 64'($signed({1'b0, s2b_r}));
      s1sq_c_r <= s1sq_b_r;
      asum = $signed({3'd0, s1sq_c_r}) + 65'(u_r);
      if (asum < 0) a_r <= '0;
      else if (asum > $signed(65'd1 << 60)) a_r <= 61'd1 << 60;
      else a_r <= asum[60:0];
    end
  end

  assign b_r = (61'd1 << 60) - a_r;

  // integer square roots of a and 1 - a, one bit per stage
  for (genvar i = 0; i < 32; i++) begin : g_sq
    hvd_pkg::sq_t pr, pq;
    if (i == 0) begin : g_first
      assign pr = '{v: {3'd0, a_r}, res: 64'd0};
      assign pq = '{v: {3'd0, b_r}, res: 64'd0};
    end else begin : g_next
      assign pr = rt_r[i-1];
      assign pq = qt_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[i] <= hvd_pkg::sq_step(pr, i);
        qt_r[i] <= hvd_pkg::sq_step(pq, i);
      end
    end
  end

  // vectoring cordic: atan2(sqrt a, sqrt(1 - a))
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_at
    logic signed [34:0] px, py;
    logic signed [33:0] pz;
    logic [31:0]        at;
    if (i == 0) begin : g_first
      assign px = $signed({4'd0, qt_r[31].res[30:0]});
      assign py = $signed({4'd0, rt_r[31].res[30:0]});
      assign pz = '0;
    end else begin : g_next
      assign px = ax_r[i-1];
      assign py = ay_r[i-1];
      assign pz = az_r[i-1];
    end
    assign at = hvd_pkg::atan_q(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (py > 0) begin
          ax_r[i] <= px + (py >>> i);
          ay_r[i] <= py - (px >>> i);
          az_r[i] <= pz + $signed({2'b00, at});
        end else begin
          ax_r[i] <= px - (py >>> i);
          ay_r[i] <= py + (px >>> i);
          az_r[i] <= pz - $signed({2'b00, at});
        end
      end
    end
  end

  // scale by the diameter, round and saturate
  always_ff @(posedge clk) begin
    logic signed [33:0] zl;
    logic [32:0]        zc;
    logic [45:0]        rnd;
    zl = az_r[CORDIC_STEPS-1];
    zc = zl[33] ? 33'd0 : zl[32:0];
    rnd = mul_r + (46'd1 << 21);
    if (en) begin
      mul_r <= {13'd0, zc} * {33'd0, hvd_pkg::DIAMETER};
      sat_r <= ((rnd >> 22) > 46'(hvd_pkg::MILES_CAP)) ? hvd_pkg::MILES_CAP : rnd[43:22];
    end
  end

  // output register with one-deep skid buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      skid_full_r  <= 1'b0;
    end else if (!out_tvalid_r || out_tready) begin
      if (skid_full_r) begin
        out_tvalid_r <= 1'b1;
        skid_full_r  <= 1'b0;
      end else begin
        out_tvalid_r <= v_r[NV-1];
      end
    end else if (en && v_r[NV-1]) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_tvalid_r || out_tready) begin
      out_r <= skid_full_r ? skid_r : sat_r;
    end else if (en && v_r[NV-1]) begin
      skid_r <= sat_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_r};

  // checks
  `HVD_ASSERT_NOW(a_skid_implies_out, skid_full_r, out_tvalid_r)
  `HVD_ASSERT_NOW(a_miles_capped, out_tvalid_r, out_r <= hvd_pkg::MILES_CAP)
  `HVD_ASSERT_NEXT(a_skid_holds, skid_full_r && !out_tready, skid_full_r && out_tvalid_r)

endmodule

>>> src/hvd_trig.sv
// pipelined angle reduction, degree to radian conversion and rotation cordic
module hvd_trig #(
  parameter int FB           = hvd_pkg::FRAC_BITS_DEF,
  parameter int RED_STEPS    = 2,
  parameter int CORDIC_STEPS = hvd_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [25:0] ang_i,
  output logic [30:0]        s_o,
  output logic signed [31:0] c_o
);

  localparam logic [63:0] FULL    = 64'd360 << FB;
  localparam logic [63:0] HALF    = 64'd180 << FB;
  localparam logic [63:0] QUARTER = 64'd90 << FB;
  localparam int          NEG_N   = CORDIC_STEPS + 6;

  logic [25:0]        abs_r;
  logic [25:0]        red_r [RED_STEPS];
  logic [25:0]        fold_r;
  logic [25:0]        fold_nxt;
  logic               fold_neg;
  logic               neg_r [NEG_N];
  logic [57:0]        prod_r;
  logic [36:0]        m_r, m3_r, m4_r;
  logic [52:0]        ph_r;
  logic [47:0]        pl_r;
  logic [31:0]        q0_r;
  logic signed [33:0] ang_r;
  logic signed [33:0] cx_r [CORDIC_STEPS];
  logic signed [33:0] cy_r [CORDIC_STEPS];
  logic signed [33:0] cz_r [CORDIC_STEPS];

  // magnitude of the incoming angle
  always_ff @(posedge clk) begin
    if (en) abs_r <= ang_i[25] ? 26'(-ang_i) : ang_i;
  end

  // modulo a full turn, one shifted subtract per stage
  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    logic [25:0] prev;
    logic [63:0] lim;
    if (j == 0) begin : g_first
      assign prev = abs_r;
    end else begin : g_next
      assign prev = red_r[j-1];
    end
    assign lim = FULL << (RED_STEPS - 1 - j);
    always_ff @(posedge clk) begin
      if (en) red_r[j] <= ({38'd0, prev} >= lim) ? 26'({38'd0, prev} - lim) : prev;
    end
  end

  // fold into the first quadrant, remember the cosine sign
  always_comb begin
    logic [63:0] xw;
    xw = {38'd0, red_r[RED_STEPS-1]};
    fold_neg = 1'b0;
    if (xw > HALF) xw = FULL - xw;
    if (xw > QUARTER) begin
      xw = HALF - xw;
      fold_neg = 1'b1;
    end
    fold_nxt = xw[25:0];
  end

  always_ff @(posedge clk) begin
    if (en) fold_r <= fold_nxt;
  end

  // sign travels beside the angle
  for (genvar k = 0; k < NEG_N; k++) begin : g_neg
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) neg_r[k] <= fold_neg;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) neg_r[k] <= neg_r[k-1];
      end
    end
  end

  // radians: round(x * pi / (180 << fb)) via shift and reciprocal of 45
  always_ff @(posedge clk) begin
    logic [63:0] sum64;
    logic [69:0] sum70;
    logic [37:0] rem;
    if (en) begin
      prod_r <= {32'd0, fold_r} * {26'd0, hvd_pkg::PI_Q};
      sum64 = {6'd0, prod_r} + QUARTER;
      m_r  <= 37'(sum64 >> (FB + 2));
      ph_r <= {32'd0, m_r[36:16]} * {21'd0, hvd_pkg::RECIP45};
      pl_r <= {32'd0, m_r[15:0]} * {16'd0, hvd_pkg::RECIP45};
      m3_r <= m_r;
      sum70 = ({17'd0, ph_r} << 16) + {22'd0, pl_r};
      q0_r <= sum70[68:37];
      m4_r <= m3_r;
      rem = {1'b0, m4_r} - ({6'd0, q0_r} * 38'd45);
      ang_r <= (rem >= 38'd45) ? $signed(34'(q0_r) + 34'd1) : $signed(34'(q0_r));
    end
  end

  // rotation cordic, one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
    logic signed [33:0] px, py, pz;
    logic [31:0]        at;
    if (i == 0) begin : g_first
      assign px = $signed({2'b00, hvd_pkg::GAIN_Q});
      assign py = '0;
      assign pz = ang_r;
    end else begin : g_next
      assign px = cx_r[i-1];
      assign py = cy_r[i-1];
      assign pz = cz_r[i-1];
    end
    assign at = hvd_pkg::atan_q(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!pz[33]) begin
          cx_r[i] <= px - (py >>> i);
          cy_r[i] <= py + (px >>> i);
          cz_r[i] <= pz - $signed({2'b00, at});
        end else begin
          cx_r[i] <= px + (py >>> i);
          cy_r[i] <= py - (px >>> i);
          cz_r[i] <= pz + $signed({2'b00, at});
        end
      end
    end
  end

  // clamp to 0..1 and apply the quadrant sign
  always_ff @(posedge clk) begin
    logic signed [33:0] xe, ye;
    logic [30:0] cs, sn;
    xe = cx_r[CORDIC_STEPS-1];
    ye = cy_r[CORDIC_STEPS-1];
    if (xe[33]) cs = '0;
    else if (xe > $signed({2'b00, hvd_pkg::ONE_Q})) cs = hvd_pkg::ONE_Q[30:0];
    else cs = xe[30:0];
    if (ye[33]) sn = '0;
    else if (ye > $signed({2'b00, hvd_pkg::ONE_Q})) sn = hvd_pkg::ONE_Q[30:0];
    else sn = ye[30:0];
    if (en) begin
      s_o <= sn;
      c_o <= neg_r[NEG_N-1] ? -$signed({1'b0, cs}) : $signed({1'b0, cs});
    end
  end

endmodule

>>> bench/testbench.sv
// self-checking testbench of the haversine distance pipeline
`timescale 1ns / 100ps

module testbench;

  localparam int NUM_RANDOM = 800;
  localparam int HOLD_CYCLES = 2500;
  localparam int HOLD_AT = 150;
  localparam int PAUSE_AT = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT = 10000;
  localparam int STEPS = 24;
  localparam longint ONE = 64'sd1 << 30;
  localparam longint LAT_MAX = 5898240;
  localparam longint LON_MAX = 11796480;
  localparam longint unsigned PI_FIX = 64'd3373259426;
  localparam longint GAIN_FIX = 64'sd652032874;
  localparam longint unsigned MILES_MAX = 64'd3181568;

  typedef struct packed {
    logic signed [23:0] src_lat;
    logic signed [24:0] src_lon;
    logic signed [23:0] dst_lat;
    logic signed [24:0] dst_lon;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [103:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;

  logic [21:0] miles_due[$];
  int errors = 0;
  int beats_out = 0;
  int quiet_cycles = 0;
  bit sending_done = 1'b0;

  haversine_distance dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // atan(2^-i) in Q2.30
  function automatic longint arctan_step(input int i);
    longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  // sine magnitude and signed cosine of an angle in degrees with fb fraction bits
  function automatic void sin_cos_deg(input longint raw, input int fb,
                                      output longint s, output longint c);
    longint unsigned full, half, quarter, x;
    longint z, cx, cy, dx, dy;
    bit neg;
    full = 64'd360 << fb;
    half = 64'd180 << fb;
    quarter = 64'd90 << fb;
    x = longint'(raw < 0 ? -raw : raw) % full;
    neg = 1'b0;
    if (x > half) x = full - x;
    if (x > quarter) begin
      x = half - x;
      neg = 1'b1;
    end
    z = longint'((x * PI_FIX + (half >> 1)) / half);
    cx = GAIN_FIX;
    cy = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= arctan_step(i);
      end else begin
        cx += dx; cy -= dy; z += arctan_step(i);
      end
    end
    if (cx < 0) cx = 0;
    if (cx > ONE) cx = ONE;
    if (cy < 0) cy = 0;
    if (cy > ONE) cy = ONE;
    s = cy;
    c = neg ? -cx : cx;
  endfunction

  // floor square root of a 64-bit value
  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // great-circle distance of one point pair in miles, 8 fraction bits
  function automatic logic [21:0] distance_miles(input pair_t p);
    longint lat1, lon1, lat2, lon2, s1, s2, c1, c2, junk, cc, t, a, y, x, z, dx, dy;
    longint unsigned m;
    lat1 = p.src_lat; lon1 = p.src_lon;
    lat2 = p.dst_lat; lon2 = p.dst_lon;
    sin_cos_deg(lat2 - lat1, 17, s1, junk);
    sin_cos_deg(lon2 - lon1, 17, s2, junk);
    sin_cos_deg(lat1, 16, junk, c1);
    sin_cos_deg(lat2, 16, junk, c2);
    cc = (c1 * c2) >>> 30;
    t = (cc * s2) >>> 30;
    a = s1 * s1 + t * s2;
    if (a < 0) a = 0;
    if (a > ONE * ONE) a = ONE * ONE;
    y = longint'(int_root(a));
    x = longint'(int_root(ONE * ONE - a));
    z = 0;
    // arcsine as vectoring cordic on (sqrt(1-a), sqrt(a))
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    if (z < 0) z = 0;
    m = (longint'(z) * 64'd7912 + (64'd1 << 21)) >> 22;
    if (m > MILES_MAX) m = MILES_MAX;
    return m[21:0];
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    if ($urandom_range(0, 9) < 7) begin
      p.src_lat = 24'($urandom_range(0, 32'(2 * LAT_MAX)) - LAT_MAX);
      p.src_lon = 25'($urandom_range(0, 32'(2 * LON_MAX)) - LON_MAX);
      p.dst_lat = 24'($urandom_range(0, 32'(2 * LAT_MAX)) - LAT_MAX);
      p.dst_lon = 25'($urandom_range(0, 32'(2 * LON_MAX)) - LON_MAX);
    end else begin
      // any bit pattern, out-of-range coordinates included
      p.src_lat = 24'($urandom);
      p.src_lon = 25'($urandom);
      p.dst_lat = 24'($urandom);
      p.dst_lon = 25'($urandom);
    end
    return p;
  endfunction

  // offer one pair after a gap and wait for its beat
  task automatic send_pair(input pair_t p, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, p.dst_lon, p.dst_lat, p.src_lon, p.src_lat};
    do @(posedge clk); while (!in_tready);
    miles_due = {miles_due, distance_miles(p)};
  endtask

  // directed pairs: extremes, antipodes, same point, wrap-around
  pair_t corner_rows[] = '{
    '{24'sd0, 25'sd0, 24'sd0, 25'sd0},
    '{24'sd5898240, 25'sd0, -24'sd5898240, 25'sd0},
    '{24'sd0, 25'sd0, 24'sd0, 25'sd11796480},
    '{24'sd0, -25'sd11796480, 24'sd0, 25'sd11796480},
    '{24'sd5898240, 25'sd11796480, 24'sd5898240, -25'sd11796480},
    '{-24'sd5898240, -25'sd11796480, -24'sd5898240, 25'sd11796480},
    '{24'sd2621440, 25'sd5898240, -24'sd2621440, -25'sd5898240},
    '{24'sd1, 25'sd1, 24'sd0, 25'sd0},
    '{24'sd2621440, -25'sd4718592, 24'sd2621440, -25'sd4718593},
    '{24'sd8388607, 25'sd16777215, 24'sh800000, 25'sh1000000},
    '{24'sh800000, 25'sh1000000, 24'sd8388607, 25'sd16777215},
    '{24'sd8388607, 25'sd16777215, 24'sd8388607, 25'sd16777215},
    '{24'sd5898240, 25'sd0, 24'sd5898240, 25'sd11796480},
    '{24'sd0, 25'sd5898240, 24'sd0, -25'sd5898240},
    '{24'sd2359296, -25'sd5242880, 24'sd3538944, 25'sd7864320},
    '{-24'sd1, -25'sd1, 24'sd1, 25'sd1}
  };

  // stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (corner_rows[i]) send_pair(corner_rows[i], $urandom_range(0, 17));
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == PAUSE_AT) begin
        in_tvalid <= 1'b0;
        while (miles_due.size() != 0) @(posedge clk);
      end
      // bursts without gaps now and then
      send_pair(rand_pair(), (n % 200 < 40) ? 0 : $urandom_range(0, 17));
    end
    in_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && beats_out >= HOLD_AT) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = ((beats_out % 150) < 30) ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare each result beat with the oldest expected distance
  always @(posedge clk) begin
    logic [21:0] due;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (miles_due.size() == 0) begin
        $error("unexpected result beat, miles %0d", out_tdata[21:0]);
        errors++;
      end else begin
        due = miles_due.pop_front();
        if (out_tdata[21:0] !== due) begin
          $error("miles mismatch: expected %0d, actual %0d", due, out_tdata[21:0]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (sending_done);
    while (miles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && miles_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
